/* hw/rtl/kmsd_pkg.sv */
`default_nettype none

package kmsd_pkg;

   localparam int ROW_COUNT  = 4;
   localparam int COL_COUNT  = 3;
   localparam int LEVEL_BITS = 12;
   localparam int CODE_W     = 4;
   localparam int CNT_W      = 4;

   // keys beyond the visible level bits read as released
   localparam int KEY_COUNT  = (ROW_COUNT * COL_COUNT > LEVEL_BITS) ?
                               LEVEL_BITS : ROW_COUNT * COL_COUNT;
   localparam int IDX_W      = $clog2(KEY_COUNT + 1);

   localparam logic [CNT_W-1:0]  CNT_MAX       = '1;
   localparam logic [CNT_W-1:0]  DEBOUNCE_RST  = 4'd2;
   localparam logic [CODE_W-1:0] NO_KEY        = '0;
   localparam logic [CODE_W-1:0] MAX_CODE      = CODE_W'(KEY_COUNT);

   typedef enum logic [0:0] {
      OP_SCAN = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [CODE_W-1:0] raw_code;
      logic [CODE_W-1:0] stable_code;
      logic [CODE_W-1:0] press_read;
   } rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/keypad_matrix_scan_debounce.sv */
// Keypad matrix scan debouncer, 4 x 3 keys.
// Request channel (req_valid / req_stall): req_opcode selects a scan frame
// or a read of the last press; req_column_levels holds one full matrix
// scan, bit row*3+col, low when pressed. One response per request on the
// rsp_ channel: raw_code of this scan, stable_code after the request, and
// press_read (the latched press on a read, which then clears).
// csr_wr_en / csr_wr_data set the number of equal scans that must repeat
// before the stable key changes; write it only while the block is idle.
// An accepted request is registered, in the skid entry if a response
// waits. One request per cycle while req_stall is low; decode and
// debounce state update take one pass of logic at the accept edge.
// A two-entry output buffer (response register plus skid register) lets
// a request in while a response waits; req_stall rises only when both
// entries are full, so a stalled receiver holds at most two responses.
// Synchronous reset clears the debounce state, the latched press and the
// buffer, and loads the threshold with 2.
`default_nettype none

module keypad_matrix_scan_debounce (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_opcode,
   input  wire logic [kmsd_pkg::LEVEL_BITS-1:0] req_column_levels,

   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [kmsd_pkg::CODE_W-1:0]   rsp_raw_code,
   output logic      [kmsd_pkg::CODE_W-1:0]   rsp_stable_code,
   output logic      [kmsd_pkg::CODE_W-1:0]   rsp_press_read,

   input  wire logic                          csr_wr_en,
   input  wire logic [kmsd_pkg::CNT_W-1:0]    csr_wr_data
);
   import kmsd_pkg::*;

   logic [CNT_W-1:0]  debounce_scans_ff;
   logic [CODE_W-1:0] stable_key_ff,    stable_key_in;
   logic [CODE_W-1:0] latched_press_ff, latched_press_in;
   logic [CODE_W-1:0] previous_code_ff, previous_code_in;
   logic [CNT_W-1:0]  repeat_count_ff,  repeat_count_in;

   rsp_type           out_ff,  out_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           skid_ff, skid_in;
   logic              skid_valid_ff, skid_valid_in;

   opcode_type        opcode;
   logic [CODE_W-1:0] scan_code;
   logic [CODE_W-1:0] raw_code;
   logic [CNT_W-1:0]  count_next;
   logic              accept_in;
   logic              take_out;
   rsp_type           result;

   kmsd_decode u_decode (
      .column_levels (req_column_levels),
      .raw_code      (scan_code)
   );

   assign opcode    = opcode_type'(req_opcode);
   assign req_stall = skid_valid_ff;
   assign accept_in = req_valid && !req_stall;
   assign take_out  = out_valid_ff && !rsp_stall;

   assign raw_code   = (opcode == OP_SCAN) ? scan_code : NO_KEY;
   assign count_next = (repeat_count_ff == CNT_MAX) ? CNT_MAX
                                                    : repeat_count_ff + 1'b1;

   // debounce and read-clear update
   always_comb begin
      stable_key_in    = stable_key_ff;
      latched_press_in = latched_press_ff;
      previous_code_in = previous_code_ff;
      repeat_count_in  = repeat_count_ff;
      if (accept_in) begin
         unique case (opcode)
            OP_SCAN: begin
               if (raw_code == previous_code_ff && raw_code != stable_key_ff) begin
                  if (count_next >= debounce_scans_ff) begin
                     stable_key_in   = raw_code;
                     repeat_count_in = '0;
                     if (raw_code != NO_KEY) begin
                        latched_press_in = raw_code;
                     end
                  end else begin
                     repeat_count_in = count_next;
                  end
               end else if (raw_code != previous_code_ff) begin
                  repeat_count_in  = CNT_W'(1);
                  previous_code_in = raw_code;
               end
            end
            OP_READ: begin
               latched_press_in = NO_KEY;
            end
            default: begin
               latched_press_in = latched_press_ff;
            end
         endcase
      end
   end

   always_comb begin
      result.raw_code    = raw_code;
      result.stable_code = stable_key_in;
      result.press_read  = (opcode == OP_READ) ? latched_press_ff : NO_KEY;
   end

   // output register with skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (take_out) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept_in;
         end
      end else if (out_valid_ff) begin
         if (accept_in) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else begin
         out_in       = result;
         out_valid_in = accept_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_scans_ff <= DEBOUNCE_RST;
         stable_key_ff     <= NO_KEY;
         latched_press_ff  <= NO_KEY;
         previous_code_ff  <= NO_KEY;
         repeat_count_ff   <= '0;
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            debounce_scans_ff <= csr_wr_data;
         end
         stable_key_ff    <= stable_key_in;
         latched_press_ff <= latched_press_in;
         previous_code_ff <= previous_code_in;
         repeat_count_ff  <= repeat_count_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_raw_code    = out_ff.raw_code;
   assign rsp_stable_code = out_ff.stable_code;
   assign rsp_press_read  = out_ff.press_read;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a response in the output register");

   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      (accept_in && opcode == OP_READ) |=> (latched_press_ff == NO_KEY))
      else $error("latched press not cleared by a read");

   a_read_no_raw: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_press_read != NO_KEY) |-> (rsp_raw_code == NO_KEY))
      else $error("read response carries a raw scan code");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_raw_code <= MAX_CODE && rsp_stable_code <= MAX_CODE))
      else $error("response code beyond the key count");

   a_press_is_stable: assert property (@(posedge clock) disable iff (reset)
      (stable_key_ff != $past(stable_key_ff) && stable_key_ff != NO_KEY)
      |-> (latched_press_ff == stable_key_ff))
      else $error("new stable key not latched as last press");

endmodule

`default_nettype wire

/* hw/rtl/kmsd_decode.sv */
`default_nettype none

module kmsd_decode (
   input  wire logic [kmsd_pkg::LEVEL_BITS-1:0] column_levels,
   output logic      [kmsd_pkg::CODE_W-1:0]     raw_code
);
   import kmsd_pkg::*;

   logic [KEY_COUNT-1:0] pressed;
   logic                 single;
   logic [IDX_W-1:0]     found;
   logic [IDX_W:0]       code_sum;

   // a key pulls its column low when pressed
   assign pressed = ~column_levels[KEY_COUNT-1:0];
   assign single  = (pressed != '0) && ((pressed & (pressed - 1'b1)) == '0);

   // with exactly one bit set, OR-ing the indices gives that index
   always_comb begin
      found = '0;
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (pressed[i]) begin
            found = found | IDX_W'(i);
         end
      end
   end

   assign code_sum = {1'b0, found} + 1'b1;
   assign raw_code = single ? CODE_W'(code_sum) : NO_KEY;

endmodule

`default_nettype wire

/* sim/keypad_matrix_scan_debounce_tb.sv */
`default_nettype none

module keypad_matrix_scan_debounce_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kmsd_pkg::*;

   localparam int HOLD_CYCLES = 120;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      opcode_type             op;
      logic [LEVEL_BITS-1:0]  levels;
   } key_request_type;

   logic                    clock;
   logic                    reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_opcode = OP_SCAN;
   logic [LEVEL_BITS-1:0]   req_column_levels = '1;

   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [CODE_W-1:0]       rsp_raw_code;
   logic [CODE_W-1:0]       rsp_stable_code;
   logic [CODE_W-1:0]       rsp_press_read;

   logic                    csr_wr_en = 1'b0;
   logic [CNT_W-1:0]        csr_wr_data = DEBOUNCE_RST;

   key_request_type         scan_requests[$];
   rsp_type                 expected_codes[$];

   // debounce state as the block should hold it
   logic [CNT_W-1:0]        debounce_threshold = DEBOUNCE_RST;
   logic [CODE_W-1:0]       stable_key = NO_KEY;
   logic [CODE_W-1:0]       latched_press = NO_KEY;
   logic [CODE_W-1:0]       previous_code = NO_KEY;
   logic [CNT_W-1:0]        repeat_count = '0;

   int                      send_idle_pct = 0;
   int                      recv_stall_pct = 0;
   bit                      hold_armed = 1'b0;
   bit                      hold_started = 1'b0;
   int                      hold_left = 0;
   int                      mismatch_count = 0;
   int                      cycle_count = 0;

   keypad_matrix_scan_debounce dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_column_levels (req_column_levels),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_raw_code      (rsp_raw_code),
      .rsp_stable_code   (rsp_stable_code),
      .rsp_press_read    (rsp_press_read),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [CODE_W-1:0] single_key_code(input logic [LEVEL_BITS-1:0] levels);
      int pressed;
      int found;
      pressed = 0;
      found = 0;
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (!levels[i]) begin
            pressed++;
            found = i;
         end
      end
      if (pressed != 1)
         return NO_KEY;
      return CODE_W'(found + 1);
   endfunction

   function automatic rsp_type debounce_step(input opcode_type op,
                                             input logic [LEVEL_BITS-1:0] levels);
      rsp_type          r;
      logic [CODE_W-1:0] code;
      r = '0;
      if (op == OP_SCAN) begin
         code = single_key_code(levels);
         r.raw_code = code;
         if (code == previous_code && code != stable_key) begin
            if (repeat_count != CNT_MAX)
               repeat_count = repeat_count + 1'b1;
            if (repeat_count >= debounce_threshold) begin
               stable_key = code;
               repeat_count = '0;
               if (code != NO_KEY)
                  latched_press = code;
            end
         end else if (code != previous_code) begin
            // a new code only starts the count
            repeat_count = CNT_W'(1);
            previous_code = code;
         end
      end else begin
         r.press_read = latched_press;
         latched_press = NO_KEY;
      end
      r.stable_code = stable_key;
      return r;
   endfunction

   task automatic report_failure(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0d] %s", cycle_count, msg);
      mismatch_count++;
   endtask

   function automatic void queue_scan(input logic [LEVEL_BITS-1:0] levels);
      scan_requests.push_back(key_request_type'{OP_SCAN, levels});
   endfunction

   function automatic void queue_read(input logic [LEVEL_BITS-1:0] levels);
      scan_requests.push_back(key_request_type'{OP_READ, levels});
   endfunction

   function automatic logic [LEVEL_BITS-1:0] one_key(input int idx);
      return ~(LEVEL_BITS'(1) << idx);
   endfunction

   // request driver
   always @(posedge clock) begin
      key_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_codes.push_back(debounce_step(opcode_type'(req_opcode), req_column_levels));
         if (!req_valid || !req_stall) begin
            if (scan_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_req = scan_requests.pop_front();
               req_valid <= 1'b1;
               req_opcode <= next_req.op;
               req_column_levels <= next_req.levels;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, armed once
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_armed && !hold_started) begin
         hold_started <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_codes.size() == 0) begin
            report_failure($sformatf("unexpected response raw %0d stable %0d press %0d",
                                     rsp_raw_code, rsp_stable_code, rsp_press_read));
         end else begin
            want = expected_codes.pop_front();
            if (rsp_raw_code !== want.raw_code)
               report_failure($sformatf("raw_code %0d, expected %0d",
                                        rsp_raw_code, want.raw_code));
            if (rsp_stable_code !== want.stable_code)
               report_failure($sformatf("stable_code %0d, expected %0d",
                                        rsp_stable_code, want.stable_code));
            if (rsp_press_read !== want.press_read)
               report_failure($sformatf("press_read %0d, expected %0d",
                                        rsp_press_read, want.press_read));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic wait_drained();
      while (scan_requests.size() != 0 || req_valid || expected_codes.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [CNT_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      debounce_threshold = value;
      @(negedge clock);
   endtask

   task automatic queue_directed();
      queue_scan('1);
      queue_scan(one_key(0));
      queue_scan(one_key(0));
      queue_scan(one_key(0));           // equal to the stable key: count holds
      queue_read(12'hABC);              // levels ignored on a read
      queue_read(12'h000);              // press already cleared
      queue_scan(one_key(11));
      queue_scan(one_key(11));
      queue_scan(12'h000);              // every key down reads as no key
      queue_scan(12'h000);
      queue_scan(12'hFFC);              // two keys down
      queue_read('1);                   // release does not clear the press
      for (int i = 1; i <= 10; i++)
         queue_scan(one_key(i));
      queue_scan(one_key(10));
      queue_read(12'h555);
      queue_scan('1);
   endtask

   // bursts of one setting, 1 to threshold + 2 scans, with bounce and reads mixed in
   task automatic queue_random(input int count);
      int                    added;
      int                    pick;
      int                    run;
      logic [LEVEL_BITS-1:0] levels;
      added = 0;
      while (added < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            levels = one_key($urandom_range(0, KEY_COUNT - 1));
         end else if (pick < 78) begin
            levels = '1;
         end else if (pick < 90) begin
            do
               levels = LEVEL_BITS'($urandom);
            while ($countones(~levels) < 2);
         end else begin
            levels = LEVEL_BITS'($urandom);
         end
         run = $urandom_range(1, int'(debounce_threshold) + 2);
         for (int k = 0; k < run; k++) begin
            if ($urandom_range(0, 9) == 0)
               queue_scan(LEVEL_BITS'($urandom));
            else
               queue_scan(levels);
            added++;
         end
         if ($urandom_range(0, 2) == 0) begin
            queue_read(LEVEL_BITS'($urandom));
            added++;
         end
      end
   endtask

   initial begin
      int thresholds[5];
      int send_pcts[5];
      int recv_pcts[5];
      thresholds = '{1, 15, 0, 0, 0};
      thresholds[2] = $urandom_range(3, 14);
      thresholds[3] = $urandom_range(2, 14);
      thresholds[4] = $urandom_range(1, 15);
      send_pcts = '{0, 57, 0, 23, 0};
      recv_pcts = '{0, 0, 57, 23, 23};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset threshold first
      queue_directed();
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         write_threshold(CNT_W'(thresholds[p]));
         send_idle_pct = send_pcts[p];
         recv_stall_pct = recv_pcts[p];
         // last phase: stall the receiver long while requests keep coming
         if (p == 4)
            hold_armed = 1'b1;
         queue_random(305);
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
